// ===== rtl/tks_pkg.sv =====
// Shared types and constants for the top-K record selector.
// Used by tks_rank_cmp, top_k_record_selector and tks_checker; no dependencies.
package tks_pkg;

  localparam int TAG_W  = 16;
  localparam int SIZE_W = 10;
  localparam int COST_W = 32;
  localparam int RANK_W = 4;
  localparam int MODE_W = 2;

  // Stream payload widths, rounded up to whole bytes.
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 136;

  // Ranking criteria held in the compare_mode register.
  localparam logic [MODE_W-1:0] MODE_COST0     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MAX_COST  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SIZE_C0   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SIZE_MAXC = 2'd3;

  // One stored record, with its two ranking keys precomputed on entry.
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] size_n;
    logic [SIZE_W-1:0] size_m;
    logic [COST_W-1:0] cost0;
    logic [COST_W-1:0] cost1;
    logic [COST_W-1:0] cost2;
    logic [SIZE_W-1:0] max_size;
    logic [COST_W-1:0] max_cost;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EMIT_RD,
    ST_EMIT_LOAD,
    ST_EMIT_WAIT
  } state_t;

endpackage

// ===== rtl/tks_rank_cmp.sv =====
// Ranking comparator shared by every slot step of an insertion.
// Depends on tks_pkg for the record type and the compare mode codes.
module tks_rank_cmp (
  input  logic [tks_pkg::MODE_W-1:0] mode,
  input  tks_pkg::rec_t              a,
  input  tks_pkg::rec_t              b,
  output logic                       ahead
);

  logic [tks_pkg::COST_W-1:0] cost_a;
  logic [tks_pkg::COST_W-1:0] cost_b;
  logic                       by_size;
  logic                       cost_lt;
  logic                       size_lt;
  logic                       size_eq;

  always_comb begin
    unique case (mode)
      tks_pkg::MODE_COST0: begin
        cost_a  = a.cost0;
        cost_b  = b.cost0;
        by_size = 1'b0;
      end
      tks_pkg::MODE_MAX_COST: begin
        cost_a  = a.max_cost;
        cost_b  = b.max_cost;
        by_size = 1'b0;
      end
      tks_pkg::MODE_SIZE_C0: begin
        cost_a  = a.cost0;
        cost_b  = b.cost0;
        by_size = 1'b1;
      end
      default: begin
        cost_a  = a.max_cost;
        cost_b  = b.max_cost;
        by_size = 1'b1;
      end
    endcase
  end

  assign cost_lt = cost_a < cost_b;
  assign size_lt = a.max_size < b.max_size;
  assign size_eq = a.max_size == b.max_size;

  // Strictly better only, so a tie keeps the earlier record ahead.
  assign ahead = by_size ? (size_lt || (size_eq && cost_lt)) : cost_lt;

endmodule

// ===== rtl/top_k_record_selector.sv =====
// Top level of the top-K record selector: slot memory, sequencer, output register.
// Depends on tks_pkg and instantiates tks_rank_cmp.
//
//   channel   direction  handshake               payload
//   s_*       in         s_tvalid / s_tready     s_tdata: record fields, s_tlast: final record
//   m_*       out        m_tvalid / m_tready     m_tdata: ranked record, m_tuser: slot filled,
//                                                m_tlast: last rank of the list
//   cfg_*     in         cfg_valid / cfg_ready   cfg_data: compare_mode
//
// An insertion accepts the record and then visits the slots in order, at most KEEP_COUNT;
// the single comparator and the slot memory (one write and one read port) handle
// one slot per cycle (the read of the next slot overlaps the compare of this one).
// After a final record each rank goes through three steps: memory read, output load and
// a handoff that lasts while m_tready is held low. Reset is synchronous and clears the slot
// fill count, so no clearing pass is needed. While an item is being worked on or the
// list is being emitted, s_tready is low.
module top_k_record_selector #(
  parameter int KEEP_COUNT = 10
) (
  input  logic                             clk,
  input  logic                             rst,
  // Fields from bit 0 up: record_tag, size_n, size_m, cost0, cost1, cost2, zero pad.
  input  logic [tks_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             s_tlast,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // Fields from bit 0 up: rank, out_tag, out_n, out_m, out_cost0, out_cost1, out_cost2.
  output logic [tks_pkg::OUT_DATA_W-1:0]   m_tdata,
  // Fields from bit 0 up: slot_filled.
  output logic                             m_tuser,
  output logic                             m_tlast,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [tks_pkg::MODE_W-1:0]       cfg_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);

  // Slot index width and fill count width (the count must hold KEEP_COUNT itself).
  localparam int IDX_W = (KEEP_COUNT > 1) ? $clog2(KEEP_COUNT) : 1;
  localparam int CNT_W = $clog2(KEEP_COUNT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEEP_COUNT - 1);

  tks_pkg::state_t              state;
  tks_pkg::state_t              state_next;
  logic [tks_pkg::MODE_W-1:0]   compare_mode;

  // Insertion and emission share one slot pointer.
  logic [IDX_W-1:0]             slot_idx;
  logic [IDX_W-1:0]             slot_idx_next;
  // Slots fill in order, so a fill count stands in for per-slot used bits.
  logic [CNT_W-1:0]             fill_count;
  logic [CNT_W-1:0]             fill_count_next;
  tks_pkg::rec_t                carry;
  tks_pkg::rec_t                carry_next;
  logic                         final_flag;
  logic                         final_flag_next;

  // Slot memory: one write and one registered read per cycle.
  tks_pkg::rec_t                slot_mem [KEEP_COUNT];
  tks_pkg::rec_t                rd_data;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  logic [IDX_W-1:0]             mem_raddr;

  // Output register.
  logic                         out_valid;
  logic                         out_valid_next;
  logic                         out_load;
  logic [tks_pkg::RANK_W-1:0]   out_rank;
  logic                         out_filled;
  logic                         out_last;
  tks_pkg::rec_t                out_rec;

  logic                         ahead;
  logic                         slot_empty;
  logic                         at_last;
  logic                         ins_done;
  tks_pkg::rec_t                in_rec;

  // Unpack the incoming record and compute its two ranking keys.
  always_comb begin
    in_rec          = '0;
    in_rec.tag      = s_tdata[15:0];
    in_rec.size_n   = s_tdata[25:16];
    in_rec.size_m   = s_tdata[35:26];
    in_rec.cost0    = s_tdata[67:36];
    in_rec.cost1    = s_tdata[99:68];
    in_rec.cost2    = s_tdata[131:100];
    in_rec.max_size = (in_rec.size_n > in_rec.size_m) ? in_rec.size_n : in_rec.size_m;
    in_rec.max_cost = (in_rec.cost1 > in_rec.cost0) ? in_rec.cost1 : in_rec.cost0;
    if (in_rec.cost2 > in_rec.max_cost) begin
      in_rec.max_cost = in_rec.cost2;
    end
  end

  tks_rank_cmp u_cmp (
    .mode  (compare_mode),
    .a     (carry),
    .b     (rd_data),
    .ahead (ahead)
  );

  assign slot_empty = CNT_W'(slot_idx) >= fill_count;
  assign at_last    = slot_idx == LAST_IDX;
  // The insertion ends at the first empty slot; past the last slot the carry is dropped.
  assign ins_done   = slot_empty || at_last;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      tks_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = tks_pkg::ST_INSERT;
        end
      end
      tks_pkg::ST_INSERT: begin
        if (ins_done) begin
          state_next = final_flag ? tks_pkg::ST_EMIT_RD : tks_pkg::ST_IDLE;
        end
      end
      tks_pkg::ST_EMIT_RD: begin
        state_next = tks_pkg::ST_EMIT_LOAD;
      end
      tks_pkg::ST_EMIT_LOAD: begin
        state_next = tks_pkg::ST_EMIT_WAIT;
      end
      tks_pkg::ST_EMIT_WAIT: begin
        if (m_tready) begin
          state_next = at_last ? tks_pkg::ST_IDLE : tks_pkg::ST_EMIT_RD;
        end
      end
      default: begin
        state_next = tks_pkg::ST_IDLE;
      end
    endcase
  end

  // Datapath control.
  always_comb begin
    slot_idx_next   = slot_idx;
    fill_count_next = fill_count;
    carry_next      = carry;
    final_flag_next = final_flag;
    mem_we          = 1'b0;
    mem_waddr       = slot_idx;
    mem_raddr       = slot_idx;
    out_load        = 1'b0;
    out_valid_next  = out_valid;
    unique case (state)
      tks_pkg::ST_IDLE: begin
        mem_raddr = '0;
        if (s_tvalid) begin
          carry_next      = in_rec;
          final_flag_next = s_tlast;
          slot_idx_next   = '0;
        end
      end
      tks_pkg::ST_INSERT: begin
        // rd_data holds the slot at slot_idx; the next slot is fetched meanwhile.
        if (slot_empty) begin
          mem_we          = 1'b1;
          fill_count_next = fill_count + CNT_W'(1);
        end else if (ahead) begin
          mem_we     = 1'b1;
          carry_next = rd_data;
        end
        if (ins_done) begin
          slot_idx_next = '0;
        end else begin
          slot_idx_next = slot_idx + IDX_W'(1);
          mem_raddr     = slot_idx + IDX_W'(1);
        end
      end
      tks_pkg::ST_EMIT_RD: begin
        mem_raddr = slot_idx;
      end
      tks_pkg::ST_EMIT_LOAD: begin
        out_load       = 1'b1;
        out_valid_next = 1'b1;
      end
      tks_pkg::ST_EMIT_WAIT: begin
        if (m_tready) begin
          out_valid_next = 1'b0;
          if (at_last) begin
            fill_count_next = '0;
            slot_idx_next   = '0;
          end else begin
            slot_idx_next = slot_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        out_valid_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= carry;
    end
    rd_data <= slot_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tks_pkg::ST_IDLE;
      compare_mode <= tks_pkg::MODE_COST0;
      slot_idx     <= '0;
      fill_count   <= '0;
      final_flag   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state      <= state_next;
      slot_idx   <= slot_idx_next;
      fill_count <= fill_count_next;
      final_flag <= final_flag_next;
      out_valid  <= out_valid_next;
      if (cfg_valid) begin
        compare_mode <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    carry <= carry_next;
    if (out_load) begin
      out_rank   <= tks_pkg::RANK_W'(slot_idx);
      out_filled <= ~slot_empty;
      out_last   <= at_last;
      // A slot never filled in this run reads as zero.
      out_rec    <= slot_empty ? '0 : rd_data;
    end
  end

  assign s_tready  = state == tks_pkg::ST_IDLE;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_valid;
  assign m_tuser   = out_filled;
  assign m_tlast   = out_last;
  assign m_tdata   = {out_rec.cost2, out_rec.cost1, out_rec.cost0,
                      out_rec.size_m, out_rec.size_n, out_rec.tag, out_rank};

endmodule

// ===== rtl/tks_checker.sv =====
// Port-level checks for the top-K record selector, bound to the top level.
// Depends on tks_pkg for the stream widths.
module tks_port_assert (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tready,
  input logic [tks_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast,
  input logic                           m_tvalid,
  input logic                           m_tready
);

  // No new record is taken while a ranked result is on offer.
  assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready while a result is pending");

  // An empty slot carries all-zero record fields.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[tks_pkg::OUT_DATA_W-1:4] == '0))
    else $error("empty slot with nonzero fields");

  // Once a rank that is not the last is taken, the next rank follows after its read and load.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> ##2
      (m_tvalid && (m_tdata[3:0] == $past(m_tdata[3:0], 3) + 4'd1)))
    else $error("ranks not emitted in order");

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled result changed");

endmodule

bind top_k_record_selector tks_port_assert u_tks_port_assert (.*);

// ===== test/tks_checker.sv =====
// Checker for the top-K record selector: watches the record, result and mode channels,
// keeps its own ranked list of candidate records and compares every emitted rank with it.
// Depends on tks_pkg for the field widths and the compare_mode codes.
module tks_checker #(
  parameter int KEEP_COUNT = 10
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [tks_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                           s_tlast,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [tks_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           m_tuser,
  input  logic                           m_tlast,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [tks_pkg::MODE_W-1:0]     cfg_data,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  output int                             fail_count,
  output int                             outstanding
);
  import tks_pkg::*;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] m;
    logic [COST_W-1:0] c0;
    logic [COST_W-1:0] c1;
    logic [COST_W-1:0] c2;
  } cand_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              filled;
    cand_t             rec;
    logic              last;
  } ranked_t;

  // Result field offsets within m_tdata.
  localparam int O_TAG = RANK_W;
  localparam int O_N   = O_TAG + TAG_W;
  localparam int O_M   = O_N + SIZE_W;
  localparam int O_C0  = O_M + SIZE_W;
  localparam int O_C1  = O_C0 + COST_W;
  localparam int O_C2  = O_C1 + COST_W;

  logic [MODE_W-1:0] mode_q;
  logic              used [KEEP_COUNT];
  cand_t             held [KEEP_COUNT];
  ranked_t           ranked_q [$];
  int                errs;

  function automatic logic [COST_W-1:0] peak_cost(cand_t r);
    logic [COST_W-1:0] v;
    v = r.c0;
    if (r.c1 > v) v = r.c1;
    if (r.c2 > v) v = r.c2;
    return v;
  endfunction

  function automatic logic [SIZE_W-1:0] peak_size(cand_t r);
    return (r.n > r.m) ? r.n : r.m;
  endfunction

  // True when a ranks strictly ahead of b; smaller is always better.
  function automatic logic beats(cand_t a, cand_t b, logic [MODE_W-1:0] mode);
    case (mode)
      MODE_COST0:    return a.c0 < b.c0;
      MODE_MAX_COST: return peak_cost(a) < peak_cost(b);
      MODE_SIZE_C0:  return (peak_size(a) < peak_size(b)) ||
                            (peak_size(a) == peak_size(b) && a.c0 < b.c0);
      default:       return (peak_size(a) < peak_size(b)) ||
                            (peak_size(a) == peak_size(b) && peak_cost(a) < peak_cost(b));
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    cand_t   carry;
    cand_t   tmp;
    ranked_t got;
    ranked_t want;
    logic    placed;
    if (rst) begin
      mode_q = MODE_COST0;
      for (int j = 0; j < KEEP_COUNT; j++) used[j] = 1'b0;
      ranked_q.delete();
      errs = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) mode_q = cfg_data;

      if (m_tvalid && m_tready) begin
        got.rank   = m_tdata[RANK_W-1:0];
        got.filled = m_tuser;
        got.rec.tag = m_tdata[O_TAG +: TAG_W];
        got.rec.n   = m_tdata[O_N +: SIZE_W];
        got.rec.m   = m_tdata[O_M +: SIZE_W];
        got.rec.c0  = m_tdata[O_C0 +: COST_W];
        got.rec.c1  = m_tdata[O_C1 +: COST_W];
        got.rec.c2  = m_tdata[O_C2 +: COST_W];
        got.last   = m_tlast;
        if (ranked_q.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("unexpected result: rank=%0d filled=%0b tag=%h", got.rank, got.filled,
                     got.rec.tag);
        end else begin
          want = ranked_q.pop_front();
          if (got !== want) begin
            errs++;
            if (errs <= 10) begin
              $display("rank %0d expected: filled=%0b tag=%h n=%0d m=%0d c=%h/%h/%h last=%0b",
                       want.rank, want.filled, want.rec.tag, want.rec.n, want.rec.m,
                       want.rec.c0, want.rec.c1, want.rec.c2, want.last);
              $display("rank %0d actual:   filled=%0b tag=%h n=%0d m=%0d c=%h/%h/%h last=%0b",
                       got.rank, got.filled, got.rec.tag, got.rec.n, got.rec.m,
                       got.rec.c0, got.rec.c1, got.rec.c2, got.last);
            end
          end
        end
      end

      if (s_tvalid && s_tready) begin
        carry.tag = s_tdata[0 +: TAG_W];
        carry.n   = s_tdata[16 +: SIZE_W];
        carry.m   = s_tdata[26 +: SIZE_W];
        carry.c0  = s_tdata[36 +: COST_W];
        carry.c1  = s_tdata[68 +: COST_W];
        carry.c2  = s_tdata[100 +: COST_W];
        // Walk the list from the top; the carried record swaps in only when strictly
        // better, so ties keep the earlier record. Past the last slot it is dropped.
        placed = 1'b0;
        for (int j = 0; j < KEEP_COUNT; j++) begin
          if (!placed) begin
            if (!used[j]) begin
              held[j] = carry;
              used[j] = 1'b1;
              placed = 1'b1;
            end else if (beats(carry, held[j], mode_q)) begin
              tmp = held[j];
              held[j] = carry;
              carry = tmp;
            end
          end
        end
        if (s_tlast) begin
          for (int j = 0; j < KEEP_COUNT; j++) begin
            want.rank   = RANK_W'(j);
            want.filled = used[j];
            want.rec    = used[j] ? held[j] : '0;
            want.last   = (j == KEEP_COUNT - 1);
            ranked_q.push_back(want);
            used[j] = 1'b0;
          end
        end
      end

      outstanding <= ranked_q.size();
      fail_count <= errs;
    end
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the top-K record selector: clock, reset, record and mode stimulus,
// random back-pressure on the result channel, and the final verdict.
// Depends on tks_pkg, top_k_record_selector and tks_checker.
module tb;
  import tks_pkg::*;

  localparam int KEEP = 10;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [MODE_W-1:0]     cfg_data = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;

  int fail_count;
  int outstanding;

  // Percent chance per record that the sender idles first, and per cycle that the
  // receiver holds m_tready low.
  int gap_pct = 0;
  int stall_pct = 0;

  // Cost0 values of the long directed list: extremes and repeated values for ties.
  logic [COST_W-1:0] dir_c0 [12] = '{32'd5, 32'd3, 32'd3, 32'd7, 32'd0, 32'hFFFF_FFFF,
                                     32'd3, 32'd1, 32'd9, 32'd2, 32'd3, 32'd0};

  always #2 clk = ~clk;

  top_k_record_selector #(.KEEP_COUNT(KEEP)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_data (cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  tks_checker #(.KEEP_COUNT(KEEP)) u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .fail_count (fail_count),
    .outstanding(outstanding)
  );

  // The receiver redraws its ready once per cycle, so stalls land on every phase of
  // the emit sequence, including the cycle the last rank is offered.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one record and hold it until the transaction completes. Every call starts at a
  // rising edge, and s_tvalid gets exactly one assignment in that step: either it drops
  // for an idle gap or it stays high with the new record.
  task automatic offer_record(input logic [TAG_W-1:0] tag, input logic [SIZE_W-1:0] n,
                              input logic [SIZE_W-1:0] m, input logic [COST_W-1:0] c0,
                              input logic [COST_W-1:0] c1, input logic [COST_W-1:0] c2,
                              input logic fin);
    if ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tdata  <= {4'b0, c2, c1, c0, m, n, tag};
    s_tlast  <= fin;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
  endtask

  // Wait until every emitted rank has been checked. One edge passes first so that a
  // final record accepted in this very step is already counted as outstanding.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Change the ranking criterion only while the block is idle. A trailing record that is
  // not final produces no result, so the insertion walk may still be running once the
  // queue is empty; the extra cycles cover a full walk over the list.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    drain_results();
    repeat (KEEP + 10) @(posedge clk);
    cfg_data  <= mode;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Costs and sizes lean toward extremes and a few shared values, so that ties under
  // every criterion are common; the rest are uniform over the full field.
  function automatic logic [COST_W-1:0] pick_cost();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return COST_W'($urandom_range(0, 3)) << 16;
      default: return COST_W'($urandom);
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return SIZE_W'($urandom_range(500, 503));
      default: return SIZE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic offer_random(input logic fin);
    offer_record(TAG_W'($urandom), pick_size(), pick_size(), pick_cost(), pick_cost(),
                 pick_cost(), fin);
  endtask

  initial begin : stimulus
    int sent;
    int len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A final record into an empty list shows one filled rank and nine
    // empty ones with zeroed fields.
    write_mode(MODE_COST0);
    offer_record(16'hFFFF, 10'd1023, 10'd0, '1, '1, '1, 1'b1);
    // Twelve records overflow the list so the two worst are dropped; repeated cost0
    // values check that ties keep the earlier record ahead.
    for (int i = 0; i < 12; i++)
      offer_record(TAG_W'(i), (i % 2) ? 10'd1023 : 10'd0, (i % 3) ? 10'd0 : 10'd1023,
                   dir_c0[i], '1 - COST_W'(i), COST_W'(i), i == 11);

    // Largest of the three costs, with a tie at the top value.
    write_mode(MODE_MAX_COST);
    offer_record(16'h0100, 10'd1, 10'd2, 32'd1,  32'd100, 32'd2,   1'b0);
    offer_record(16'h0101, 10'd3, 10'd4, 32'd50, 32'd3,   32'd4,   1'b0);
    offer_record(16'h0102, 10'd5, 10'd6, 32'd0,  32'd0,   32'd100, 1'b0);
    offer_record(16'h0103, 10'd7, 10'd8, 32'd60, 32'd60,  32'd60,  1'b1);

    // Smaller size first, smaller cost0 on equal size, including a full tie.
    write_mode(MODE_SIZE_C0);
    offer_record(16'h0200, 10'd1023, 10'd5,    32'd7, 32'd0, 32'd0, 1'b0);
    offer_record(16'h0201, 10'd4,    10'd1023, 32'd3, 32'd9, 32'd9, 1'b0);
    offer_record(16'h0202, 10'd0,    10'd0,    32'd9, 32'd1, 32'd1, 1'b0);
    offer_record(16'h0203, 10'd1023, 10'd1023, 32'd3, 32'd0, 32'd0, 1'b1);

    // Smaller size first, smaller largest cost on equal size.
    write_mode(MODE_SIZE_MAXC);
    offer_record(16'h0300, 10'd10, 10'd20, 32'd5, 32'd90, 32'd0,  1'b0);
    offer_record(16'h0301, 10'd20, 10'd3,  32'd80, 32'd1, 32'd2,  1'b0);
    offer_record(16'h0302, 10'd20, 10'd20, 32'd0, 32'd0,  32'd85, 1'b0);
    offer_record(16'h0303, 10'd0,  10'd20, 32'd1, 32'd1,  32'd1,  1'b1);

    // Random part: eight phases that cycle through the idle patterns and the ranking
    // criteria. Each phase is a run of lists closed by a final record; a phase may end
    // with a few records left in the list, carried across the next mode change. Every
    // mode change drains all results first, which doubles as the full sender pause.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin gap_pct <= 0;  stall_pct <= 0;  end
        1: begin gap_pct <= 55; stall_pct <= 0;  end
        2: begin gap_pct <= 0;  stall_pct <= 55; end
        default: begin gap_pct <= 8; stall_pct <= 8; end
      endcase
      case (p)
        0: write_mode(MODE_SIZE_MAXC);
        1: write_mode(MODE_COST0);
        2: write_mode(MODE_MAX_COST);
        3: write_mode(MODE_SIZE_C0);
        default: write_mode(MODE_W'($urandom_range(0, 3)));
      endcase
      sent = 0;
      while (sent < 8) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(KEEP, KEEP + 4)
                                       : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) offer_random(i == len - 1);
        sent += len;
      end
      if ($urandom_range(1) == 1)
        repeat ($urandom_range(1, 3)) offer_random(1'b0);
    end
    // Close the last list so any carried records are emitted and checked.
    offer_random(1'b1);

    drain_results();
    repeat (40) @(posedge clk);
    if (fail_count == 0 && outstanding == 0)
      $display("top_k_record_selector verification clean");
    else
      $display("top_k_record_selector verification failed");
    $finish;
  end

  // Hang guard, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("top_k_record_selector verification failed");
    $finish;
  end

endmodule
